// ===== hw/rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and fixed-point widths of the segment/plane intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int NORM_W    = 18;
	localparam int DIST_W    = 32;
	localparam int LIM_W     = 16;
	localparam int T_W       = FRAC_BITS + 1;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int PROD_W    = EDGE_W + NORM_W;
	localparam int VAL_W     = ((PROD_W + 2 > DIST_W + FRAC_BITS + 1) ?
		(PROD_W + 2) : (DIST_W + FRAC_BITS + 1)) + 1;
	localparam int MUL_W     = EDGE_W + T_W + 1;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	typedef enum logic [2:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_DIST     = 3'd3,
		REG_LIMIT    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
	} seg_t;

	typedef struct packed {
		logic                      hit;
		logic [T_W-1:0]            param_t;
		logic signed [COORD_W-1:0] cross_x;
		logic signed [COORD_W-1:0] cross_y;
		logic signed [COORD_W-1:0] cross_z;
	} res_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic signed [DIST_W-1:0] plane_dist;
		logic [LIM_W-1:0]         near_zero_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} coord3_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] x;
		logic signed [EDGE_W-1:0] y;
		logic signed [EDGE_W-1:0] z;
	} edge3_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] den;
		logic signed [VAL_W-1:0] num;
		coord3_t                 start;
		edge3_t                  edge_v;
	} dot_t;

	typedef struct packed {
		logic    hit;
		coord3_t start;
		edge3_t  edge_v;
	} side_t;

endpackage

// ===== hw/rtl/spi_regs.sv =====
// ----------------------------------------------------------------------------
// spi_regs
// APB configuration registers holding the plane and the parallel threshold.
// ----------------------------------------------------------------------------
module spi_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spi_pkg::ADDR_W-1:0] paddr,
	input  logic [spi_pkg::DATA_W-1:0] pwdata,
	output logic [spi_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output spi_pkg::cfg_t              cfg
);
	import spi_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x        <= '0;
			cfg_q.normal_y        <= '0;
			cfg_q.normal_z        <= NORM_W'(1) << FRAC_BITS;
			cfg_q.plane_dist      <= '0;
			cfg_q.near_zero_limit <= LIM_W'(1);
		end else if (wr) begin
			unique case (idx)
				REG_NORMAL_X: cfg_q.normal_x        <= pwdata[NORM_W-1:0];
				REG_NORMAL_Y: cfg_q.normal_y        <= pwdata[NORM_W-1:0];
				REG_NORMAL_Z: cfg_q.normal_z        <= pwdata[NORM_W-1:0];
				REG_DIST:     cfg_q.plane_dist      <= pwdata[DIST_W-1:0];
				REG_LIMIT:    cfg_q.near_zero_limit <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_NORMAL_X: prdata = DATA_W'(cfg_q.normal_x);
			REG_NORMAL_Y: prdata = DATA_W'(cfg_q.normal_y);
			REG_NORMAL_Z: prdata = DATA_W'(cfg_q.normal_z);
			REG_DIST:     prdata = DATA_W'(cfg_q.plane_dist);
			REG_LIMIT:    prdata = DATA_W'(cfg_q.near_zero_limit);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/spi_dot.sv =====
// ----------------------------------------------------------------------------
// spi_dot
// Three-stage front end: edge vector, six products, denominator and numerator.
// ----------------------------------------------------------------------------
module spi_dot (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  spi_pkg::seg_t seg,
	input  spi_pkg::cfg_t cfg,
	output logic          out_valid,
	output spi_pkg::dot_t dot
);
	import spi_pkg::*;

	logic    v_s1, v_s2, v_s3;
	coord3_t start_s1, start_s2;
	edge3_t  edge_s1, edge_s2;
	logic signed [PROD_W-1:0] pe_x_s2, pe_y_s2, pe_z_s2;
	logic signed [PROD_W-1:0] ps_x_s2, ps_y_s2, ps_z_s2;
	dot_t    dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_s1.x <= seg.start_x;
			start_s1.y <= seg.start_y;
			start_s1.z <= seg.start_z;
			edge_s1.x  <= EDGE_W'(seg.end_x) - EDGE_W'(seg.start_x);
			edge_s1.y  <= EDGE_W'(seg.end_y) - EDGE_W'(seg.start_y);
			edge_s1.z  <= EDGE_W'(seg.end_z) - EDGE_W'(seg.start_z);

			start_s2 <= start_s1;
			edge_s2  <= edge_s1;
			pe_x_s2  <= PROD_W'(cfg.normal_x) * PROD_W'(edge_s1.x);
			pe_y_s2  <= PROD_W'(cfg.normal_y) * PROD_W'(edge_s1.y);
			pe_z_s2  <= PROD_W'(cfg.normal_z) * PROD_W'(edge_s1.z);
			ps_x_s2  <= PROD_W'(cfg.normal_x) * PROD_W'(start_s1.x);
			ps_y_s2  <= PROD_W'(cfg.normal_y) * PROD_W'(start_s1.y);
			ps_z_s2  <= PROD_W'(cfg.normal_z) * PROD_W'(start_s1.z);

			dot_s3.den    <= VAL_W'(pe_x_s2) + VAL_W'(pe_y_s2) + VAL_W'(pe_z_s2);
			dot_s3.num    <= (VAL_W'(cfg.plane_dist) <<< FRAC_BITS)
				- VAL_W'(ps_x_s2) - VAL_W'(ps_y_s2) - VAL_W'(ps_z_s2);
			dot_s3.start  <= start_s2;
			dot_s3.edge_v <= edge_s2;
		end
	end

	assign out_valid = v_s3;
	assign dot       = dot_s3;

endmodule

// ===== hw/rtl/spi_div.sv =====
// ----------------------------------------------------------------------------
// spi_div
// Pipelined restoring divider, one quotient bit per stage, for |num| <= |den|.
// ----------------------------------------------------------------------------
module spi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [spi_pkg::VAL_W-1:0]   dividend,
	input  logic [spi_pkg::VAL_W-1:0]   divisor,
	input  spi_pkg::side_t              side_in,
	output logic                        out_valid,
	output logic [spi_pkg::T_W-1:0]     quo,
	output spi_pkg::side_t              side_out
);
	import spi_pkg::*;

	logic [VAL_W:0]   rem_s  [1:T_W];
	logic [VAL_W-1:0] dvs_s  [1:T_W];
	logic [T_W-1:0]   quo_s  [1:T_W];
	logic             val_s  [1:T_W];
	side_t            side_s [1:T_W];

	for (genvar k = 1; k <= T_W; k++) begin : g_stage
		logic [VAL_W:0]   trial;
		logic [VAL_W-1:0] dvs;
		logic [T_W-1:0]   qin;
		logic             vin;
		side_t            sin;
		logic             ge;

		if (k == 1) begin : g_first
			// The integer bit: no shift before the first trial subtraction.
			assign trial = {1'b0, dividend};
			assign dvs   = divisor;
			assign qin   = '0;
			assign vin   = in_valid;
			assign sin   = side_in;
		end else begin : g_next
			assign trial = rem_s[k-1] << 1;
			assign dvs   = dvs_s[k-1];
			assign qin   = quo_s[k-1];
			assign vin   = val_s[k-1];
			assign sin   = side_s[k-1];
		end

		assign ge = trial >= {1'b0, dvs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k] <= 1'b0;
			end else if (en) begin
				val_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (trial - {1'b0, dvs}) : trial;
				dvs_s[k]  <= dvs;
				quo_s[k]  <= {qin[T_W-2:0], ge};
				side_s[k] <= sin;
			end
		end
	end

	assign out_valid = val_s[T_W];
	assign quo       = quo_s[T_W];
	assign side_out  = side_s[T_W];

endmodule

// ===== hw/rtl/segment_plane_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_plane_intersect
// Tests streamed 3-D segments against a configured plane and reports the hit.
// ----------------------------------------------------------------------------
// Usage: software programs the plane (unit normal in Q1.16, distance in
// Q16.16) and the parallel threshold over the APB port while no transaction
// is in flight. Segments arrive on the seg channel as two Q16.16 endpoints;
// each produces exactly one transaction on the res channel, in order, with
// the hit flag, t in Q1.16 and the crossing point (all zero on a miss).
// Throughput is one segment per cycle while seg_ready is high; the
// pipelined divider sets the depth. A segment passes the edge/product/sum
// stages, the classify stage, 17 divider stages (one quotient bit each),
// the edge*t stage and the output register on its way to res valid.
// Reset clears all valid bits and loads the register defaults (normal along
// +z, distance 0, threshold 1). When the receiver stalls, the whole pipeline
// freezes in place and seg_ready drops; nothing is lost or repeated, and a
// new segment is still taken while a result waits as long as res_ready is
// high or the output stage is empty.
// ----------------------------------------------------------------------------
module segment_plane_intersect (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       seg_valid,
	output logic                       seg_ready,
	input  spi_pkg::seg_t              seg,
	output logic                       res_valid,
	input  logic                       res_ready,
	output spi_pkg::res_t              res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spi_pkg::ADDR_W-1:0] paddr,
	input  logic [spi_pkg::DATA_W-1:0] pwdata,
	output logic [spi_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import spi_pkg::*;

	cfg_t cfg;
	logic en;
	logic dot_valid;
	dot_t dot;

	// One enable moves every stage; it is high whenever the output register
	// is empty or being drained this cycle.
	assign en        = !res_valid || res_ready;
	assign seg_ready = en;

	spi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spi_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (seg_valid),
		.seg       (seg),
		.cfg       (cfg),
		.out_valid (dot_valid),
		.dot       (dot)
	);

	// Classify stage. A zero denominator is always parallel, as is one below
	// the threshold. A segment crosses within its length when the numerator is
	// zero or shares the sign of the denominator, and |num| <= |den|.
	logic [VAL_W-1:0] an, ad, lim_sh;
	logic             num_pos, den_pos, hit_c;
	logic             v_s4;
	logic [VAL_W-1:0] an_s4, ad_s4;
	side_t            side_s4;

	assign an      = dot.num[VAL_W-1] ? VAL_W'(-dot.num) : VAL_W'(dot.num);
	assign ad      = dot.den[VAL_W-1] ? VAL_W'(-dot.den) : VAL_W'(dot.den);
	assign lim_sh  = VAL_W'(cfg.near_zero_limit) << FRAC_BITS;
	assign num_pos = !dot.num[VAL_W-1] && (dot.num != '0);
	assign den_pos = !dot.den[VAL_W-1] && (dot.den != '0);
	assign hit_c   = (dot.den != '0) && !(ad < lim_sh)
		&& !((dot.num != '0) && (num_pos != den_pos)) && (an <= ad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= dot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s4          <= an;
			ad_s4          <= ad;
			side_s4.hit    <= hit_c;
			side_s4.start  <= dot.start;
			side_s4.edge_v <= dot.edge_v;
		end
	end

	// t = |num| / |den|, truncated to FRAC_BITS fraction bits.
	logic           div_valid;
	logic [T_W-1:0] quo;
	side_t          side_d;

	spi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.dividend  (an_s4),
		.divisor   (ad_s4),
		.side_in   (side_s4),
		.out_valid (div_valid),
		.quo       (quo),
		.side_out  (side_d)
	);

	// Edge times t, one multiplier per axis.
	logic                    v_s5;
	logic signed [MUL_W-1:0] mx_s5, my_s5, mz_s5;
	logic [T_W-1:0]          t_s5;
	logic                    hit_s5;
	coord3_t                 start_s5;
	logic signed [MUL_W-1:0] tq;

	assign tq = MUL_W'($signed({1'b0, quo}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			v_s5      <= div_valid;
			res_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s5    <= MUL_W'(side_d.edge_v.x) * tq;
			my_s5    <= MUL_W'(side_d.edge_v.y) * tq;
			mz_s5    <= MUL_W'(side_d.edge_v.z) * tq;
			t_s5     <= quo;
			hit_s5   <= side_d.hit;
			start_s5 <= side_d.start;
		end
	end

	// The arithmetic shift floors toward minus infinity; the point always
	// lies between the endpoints, so truncation to the coordinate is exact.
	logic signed [MUL_W-1:0] px, py, pz;

	assign px = MUL_W'(start_s5.x) + (mx_s5 >>> FRAC_BITS);
	assign py = MUL_W'(start_s5.y) + (my_s5 >>> FRAC_BITS);
	assign pz = MUL_W'(start_s5.z) + (mz_s5 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			res.hit     <= hit_s5;
			res.param_t <= hit_s5 ? t_s5 : '0;
			res.cross_x <= hit_s5 ? px[COORD_W-1:0] : '0;
			res.cross_y <= hit_s5 ? py[COORD_W-1:0] : '0;
			res.cross_z <= hit_s5 ? pz[COORD_W-1:0] : '0;
		end
	end

endmodule

// ===== verif/tb_segment_plane_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_plane_intersect
// Streams segments through the plane intersection block, predicts every
// result in the bench and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_segment_plane_intersect;
	import spi_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                seg_valid;
	logic                seg_ready;
	seg_t                seg;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	segment_plane_intersect dut (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// The bench's own copy of the plane registers, mirrored on every write.
	longint plane_nx, plane_ny, plane_nz, plane_d;
	longint plane_lim;

	seg_t   seg_pending[$];
	res_t   hits_expected[$];
	int     mismatch_count;
	int     quiet_cycles;
	int     accepted_segs;
	int     total_segs;
	bit     calm_phase;
	int     send_idle;
	int     recv_idle;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Floor division by 2^FRAC_BITS; the shift on a signed longint is
	// arithmetic, which rounds toward minus infinity.
	function automatic longint floor_frac(longint a);
		return a >>> FRAC_BITS;
	endfunction

	function automatic res_t plane_crossing(seg_t s);
		res_t   r;
		longint sp[3], ep[3], ev[3];
		longint den, num, an, ad, q, rem, pt;
		bit     hit;
		r = '0;
		sp[0] = s.start_x; sp[1] = s.start_y; sp[2] = s.start_z;
		ep[0] = s.end_x;   ep[1] = s.end_y;   ep[2] = s.end_z;
		for (int i = 0; i < 3; i++) ev[i] = ep[i] - sp[i];
		den = plane_nx * ev[0] + plane_ny * ev[1] + plane_nz * ev[2];
		num = (plane_d <<< FRAC_BITS)
			- (plane_nx * sp[0] + plane_ny * sp[1] + plane_nz * sp[2]);
		ad = (den < 0) ? -den : den;
		an = (num < 0) ? -num : num;
		hit = 1'b1;
		// A zero denominator is parallel even when the threshold is zero.
		if (den == 0 || ad < (plane_lim <<< FRAC_BITS))
			hit = 1'b0;
		else if (num != 0 && ((num > 0) != (den > 0)))
			hit = 1'b0;
		else if (an > ad)
			hit = 1'b0;
		if (!hit)
			return r;
		// Long division, truncated to FRAC_BITS fraction bits.
		q = (an >= ad) ? 1 : 0;
		rem = an - q * ad;
		for (int i = 0; i < FRAC_BITS; i++) begin
			rem = rem <<< 1;
			q = q <<< 1;
			if (rem >= ad) begin
				rem = rem - ad;
				q = q | 1;
			end
		end
		r.hit = 1'b1;
		r.param_t = q[T_W-1:0];
		pt = sp[0] + floor_frac(ev[0] * q); r.cross_x = pt[COORD_W-1:0];
		pt = sp[1] + floor_frac(ev[1] * q); r.cross_y = pt[COORD_W-1:0];
		pt = sp[2] + floor_frac(ev[2] * q); r.cross_z = pt[COORD_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Driver: holds the segment until it is taken, idles in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid <= 1'b0;
			seg <= '0;
			send_idle <= 0;
		end else begin
			if (seg_valid && seg_ready) begin
				accepted_segs <= accepted_segs + 1;
				hits_expected.push_back(plane_crossing(seg));
			end
			if (!seg_valid || seg_ready) begin
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					seg_valid <= 1'b0;
				end else if (seg_pending.size() > 0) begin
					seg <= seg_pending.pop_front();
					seg_valid <= 1'b1;
					if (!calm_phase && $urandom_range(0, 9) == 0)
						send_idle <= $urandom_range(1, 9);
				end else begin
					seg_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest prediction and
	// stalls the result channel in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_idle <= 0;
			quiet_cycles <= 0;
		end else begin
			if (res_valid && res_ready) begin
				res_t want;
				quiet_cycles <= 0;
				if (hits_expected.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = hits_expected.pop_front();
					if (res.hit !== want.hit) report_mismatch("hit", res.hit, want.hit);
					if (res.param_t !== want.param_t)
						report_mismatch("param_t", res.param_t, want.param_t);
					if (res.cross_x !== want.cross_x)
						report_mismatch("cross_x", res.cross_x, want.cross_x);
					if (res.cross_y !== want.cross_y)
						report_mismatch("cross_y", res.cross_y, want.cross_y);
					if (res.cross_z !== want.cross_z)
						report_mismatch("cross_z", res.cross_z, want.cross_z);
				end
			end else if (seg_valid && seg_ready) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (recv_idle > 0) begin
				recv_idle <= recv_idle - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if (!calm_phase && $urandom_range(0, 9) == 0)
					recv_idle <= $urandom_range(1, 9);
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired");
			$display("== FAIL ==");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle; the bench copy follows.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_NORMAL_X: plane_nx = longint'($signed(value[NORM_W-1:0]));
			REG_NORMAL_Y: plane_ny = longint'($signed(value[NORM_W-1:0]));
			REG_NORMAL_Z: plane_nz = longint'($signed(value[NORM_W-1:0]));
			REG_DIST:     plane_d = longint'($signed(value[DIST_W-1:0]));
			REG_LIMIT:    plane_lim = longint'(value[LIM_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic write_plane(longint nx, longint ny, longint nz, longint d, longint lim);
		write_reg(REG_NORMAL_X, DATA_W'(nx));
		write_reg(REG_NORMAL_Y, DATA_W'(ny));
		write_reg(REG_NORMAL_Z, DATA_W'(nz));
		write_reg(REG_DIST, DATA_W'(d));
		write_reg(REG_LIMIT, DATA_W'(lim));
	endtask

	// Waits until every queued segment is taken and every result is back,
	// then lets the pipeline settle. The check runs on the falling edge so
	// that the driver's updates of the rising edge are already visible.
	task automatic drain_block();
		while (seg_pending.size() > 0 || seg_valid || hits_expected.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic seg_t make_seg(longint sx, longint sy, longint sz,
			longint ex, longint ey, longint ez);
		seg_t s;
		s.start_x = sx[31:0]; s.start_y = sy[31:0]; s.start_z = sz[31:0];
		s.end_x = ex[31:0];   s.end_y = ey[31:0];   s.end_z = ez[31:0];
		return s;
	endfunction

	function automatic longint rand_coord(int span);
		// Mostly small coordinates so segments cross the plane often; a few
		// full-range values exercise every bit.
		case ($urandom_range(0, 3))
			0: return longint'($signed($urandom()));
			default: return longint'($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic seg_t rand_seg();
		int span;
		longint sx, sy, sz;
		span = 1 << $urandom_range(8, 22);
		sx = rand_coord(span); sy = rand_coord(span); sz = rand_coord(span);
		case ($urandom_range(0, 3))
			// Parallel to a z plane: same z at both ends.
			0: return make_seg(sx, sy, sz, rand_coord(span), rand_coord(span), sz);
			// Degenerate segment of zero length.
			1: if ($urandom_range(0, 3) == 0) return make_seg(sx, sy, sz, sx, sy, sz);
			default: ;
		endcase
		// Straddle the origin region so many segments cross the plane.
		return make_seg(sx, sy, -sz, rand_coord(span), rand_coord(span), sz);
	endfunction

	localparam longint ONE = 65536;
	localparam longint MAXC = 64'sh7FFFFFFF;
	localparam longint MINC = -64'sh80000000;

	initial begin
		longint nx, ny, nz;
		arst_n = 1'b0;
		seg_valid = 1'b0; seg = '0; res_ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatch_count = 0; quiet_cycles = 0; accepted_segs = 0;
		calm_phase = 1'b0; send_idle = 0; recv_idle = 0;
		total_segs = 950;
		plane_nx = 0; plane_ny = 0; plane_nz = ONE; plane_d = 0; plane_lim = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed segments against the reset plane z = 0.
		seg_pending.push_back(make_seg(0, 0, -ONE, 0, 0, ONE));       // midpoint hit
		seg_pending.push_back(make_seg(5, 7, 0, 9, 9, ONE));          // t = 0
		seg_pending.push_back(make_seg(5, 7, -ONE, 9, 9, 0));         // t = 1
		seg_pending.push_back(make_seg(1, 2, ONE, 3, 4, ONE));        // zero denominator
		seg_pending.push_back(make_seg(0, 0, ONE, 0, 0, 2 * ONE));    // wrong sign
		seg_pending.push_back(make_seg(0, 0, -2 * ONE, 0, 0, -ONE));  // beyond end
		seg_pending.push_back(make_seg(0, 0, 0, 0, 0, 1));            // at the limit
		seg_pending.push_back(make_seg(MINC, MAXC, MINC, MAXC, MINC, MAXC));
		seg_pending.push_back(make_seg(MAXC, MINC, MAXC, MINC, MAXC, MINC));
		seg_pending.push_back(make_seg(MAXC, MAXC, -1, MINC, MINC, 2));
		seg_pending.push_back(make_seg(-1, -1, -1, 0, 0, 0));
		seg_pending.push_back(make_seg(0, 0, -3, MAXC, MINC, 7));     // floor rounding
		drain_block();

		// Extreme plane: negative normal, extreme distance, zero threshold.
		write_plane(-ONE, 0, 0, MAXC, 0);
		seg_pending.push_back(make_seg(MAXC, 0, 0, MINC, 0, 0));
		seg_pending.push_back(make_seg(0, 0, 0, 0, 0, 0));
		seg_pending.push_back(make_seg(MINC, 5, 5, MAXC, 5, 5));
		drain_block();
		write_plane(ONE, ONE, -ONE, MINC, 65535);
		seg_pending.push_back(make_seg(MAXC, MAXC, MINC, MINC, MINC, MAXC));
		seg_pending.push_back(make_seg(MINC, MINC, MAXC, MAXC, MAXC, MINC));
		drain_block();

		// Random phases, each under a new plane.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin nx = 0; ny = 0; nz = ONE; end
				1: begin nx = 46341; ny = 0; nz = -46341; end
				2: begin nx = 37837; ny = -37837; nz = 37837; end
				default: begin
					nx = longint'($urandom_range(0, 2 * ONE)) - ONE;
					ny = longint'($urandom_range(0, 2 * ONE)) - ONE;
					nz = longint'($urandom_range(0, 2 * ONE)) - ONE;
				end
			endcase
			write_plane(nx, ny, nz,
				(phase == 7) ? longint'($signed($urandom())) :
					longint'($urandom_range(0, 2000)) - 1000,
				(phase == 5) ? 65535 : $urandom_range(0, 3));
			if (phase == 7) calm_phase = 1'b1;
			for (int k = 0; k < total_segs / 8; k++)
				seg_pending.push_back(rand_seg());
			drain_block();
		end

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
